>>> hw/rtl/sfmt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfmt_pkg
// Shared constants and types for the S/PDIF subframe formatter.
// ----------------------------------------------------------------------------
package sfmt_pkg;

    // block geometry
    localparam int FRAMES_PER_BLOCK = 192;
    localparam int FRAME_W          = $clog2(FRAMES_PER_BLOCK);

    // channel-status word
    localparam int STATUS_BITS  = 48;
    localparam int STATUS_IDX_W = $clog2(STATUS_BITS);

    // subframe layout
    localparam int WORD_W     = 32;
    localparam int SAMPLE_W   = 32;
    localparam int AUDIO_W    = 24;
    localparam int PRE_W      = 4;
    localparam int NARROW_W   = 16;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = STATUS_BITS;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WIDE_SAMPLES   = 3'd0,
        CFG_STATUS_LEFT    = 3'd1,
        CFG_STATUS_RIGHT   = 3'd2,
        CFG_PRE_BLOCK      = 3'd3,
        CFG_PRE_LEFT       = 3'd4,
        CFG_PRE_RIGHT      = 3'd5
    } t_cfg_idx;

    // per-lane formatting controls
    typedef struct packed {
        logic                   wide;
        logic [PRE_W-1:0]       preamble;
        logic [STATUS_BITS-1:0] status;
        logic [FRAME_W-1:0]     frame;
    } t_lane_ctrl;

endpackage

>>> hw/rtl/sfmt_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfmt_lane
// Formats one sample into a subframe word: audio placement, preamble and
// channel-status bit.
// ----------------------------------------------------------------------------
module sfmt_lane
    import sfmt_pkg::*;
(
    input  logic [SAMPLE_W-1:0] i_sample,
    input  t_lane_ctrl          i_ctrl,
    output logic [WORD_W-1:0]   o_word
);

    logic [AUDIO_W-1:0] audio;
    logic               st_bit;

    // audio: top 24 bits in wide mode, low 16 bits left-aligned otherwise
    always_comb begin
        if (i_ctrl.wide) begin
            audio = i_sample[SAMPLE_W-1 -: AUDIO_W];
        end else begin
            audio = {i_sample[NARROW_W-1:0], {(AUDIO_W-NARROW_W){1'b0}}};
        end
    end

    // status bit only for frames 1..47
    always_comb begin
        if ((i_ctrl.frame != '0) && (i_ctrl.frame < FRAME_W'(STATUS_BITS))) begin
            st_bit = i_ctrl.status[i_ctrl.frame[STATUS_IDX_W-1:0]];
        end else begin
            st_bit = 1'b0;
        end
    end

    assign o_word = {1'b0, st_bit, 2'b00, audio, i_ctrl.preamble};

endmodule

>>> hw/rtl/sfmt_merge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfmt_merge
// Holds the two lane words of a frame and sends them out left then right.
// ----------------------------------------------------------------------------
module sfmt_merge
    import sfmt_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [WORD_W-1:0] i_left_word,
    input  logic [WORD_W-1:0] i_right_word,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [WORD_W-1:0] o_word,
    output logic              o_last
);

    logic              r_full;
    logic              r_phase;
    logic [WORD_W-1:0] r_left;
    logic [WORD_W-1:0] r_right;
    logic              last_out;
    logic              load;

    // right word leaving frees the pair buffer this cycle
    assign last_out = r_full && r_phase && !i_stall;
    assign o_stall  = r_full && !last_out;
    assign load     = i_valid && !o_stall;

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full  <= 1'b0;
            r_phase <= 1'b0;
        end else begin
            if (load) begin
                r_full  <= 1'b1;
                r_phase <= 1'b0;
            end else if (last_out) begin
                r_full  <= 1'b0;
                r_phase <= 1'b0;
            end else if (r_full && !i_stall) begin
                r_phase <= 1'b1;
            end
        end
    end

    // pair buffer
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_left  <= i_left_word;
            r_right <= i_right_word;
        end
    end

    assign o_valid = r_full;
    assign o_word  = r_phase ? r_right : r_left;
    assign o_last  = r_phase;

endmodule

>>> hw/rtl/spdif_subframe_formatter_core.sv
`timescale 1ns / 1ps
// Flow: a frame accepted at a clock edge is registered in the pair buffer;
//   its left word shows after that edge, the right word once the left leaves.
// Output: each frame leaves as two words on the single-word output channel.
//   A new frame is taken in the cycle its predecessor's right word leaves.
// Reset (synchronous, active low): frame counter and all config registers
//   go to 0, the output buffer empties.
// ----------------------------------------------------------------------------
// spdif_subframe_formatter_core
// Two lanes format the left and right subframes of a frame side by side;
// a merge stage sends them out as consecutive words.
// ----------------------------------------------------------------------------
module spdif_subframe_formatter_core
    import sfmt_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // frame input
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [SAMPLE_W-1:0]   i_left_sample,
    input  logic [SAMPLE_W-1:0]   i_right_sample,
    // subframe output
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [WORD_W-1:0]     o_subframe_word,
    output logic                  o_frame_done
);

    logic                   r_wide;
    logic [STATUS_BITS-1:0] r_status_l;
    logic [STATUS_BITS-1:0] r_status_r;
    logic [PRE_W-1:0]       r_pre_block;
    logic [PRE_W-1:0]       r_pre_left;
    logic [PRE_W-1:0]       r_pre_right;
    logic [FRAME_W-1:0]     r_frame;
    logic [FRAME_W-1:0]     n_frame;

    t_lane_ctrl        ctrl_l;
    t_lane_ctrl        ctrl_r;
    logic [WORD_W-1:0] word_l;
    logic [WORD_W-1:0] word_r;
    logic              accept;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wide      <= 1'b0;
            r_status_l  <= '0;
            r_status_r  <= '0;
            r_pre_block <= '0;
            r_pre_left  <= '0;
            r_pre_right <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_WIDE_SAMPLES: r_wide      <= i_cfg_data[0];
                CFG_STATUS_LEFT:  r_status_l  <= i_cfg_data;
                CFG_STATUS_RIGHT: r_status_r  <= i_cfg_data;
                CFG_PRE_BLOCK:    r_pre_block <= i_cfg_data[PRE_W-1:0];
                CFG_PRE_LEFT:     r_pre_left  <= i_cfg_data[PRE_W-1:0];
                CFG_PRE_RIGHT:    r_pre_right <= i_cfg_data[PRE_W-1:0];
                default: ;
            endcase
        end
    end

    assign accept = i_in_valid && !o_in_stall;

    // frame counter, wraps at block end
    always_comb begin
        if (r_frame == FRAME_W'(FRAMES_PER_BLOCK - 1)) begin
            n_frame = '0;
        end else begin
            n_frame = r_frame + FRAME_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame <= '0;
        end else if (accept) begin
            r_frame <= n_frame;
        end
    end

    // lane controls
    always_comb begin
        ctrl_l.wide     = r_wide;
        ctrl_l.preamble = (r_frame == '0) ? r_pre_block : r_pre_left;
        ctrl_l.status   = r_status_l;
        ctrl_l.frame    = r_frame;
        ctrl_r.wide     = r_wide;
        ctrl_r.preamble = r_pre_right;
        ctrl_r.status   = r_status_r;
        ctrl_r.frame    = r_frame;
    end

    sfmt_lane u_lane_l (
        .i_sample (i_left_sample),
        .i_ctrl   (ctrl_l),
        .o_word   (word_l)
    );

    sfmt_lane u_lane_r (
        .i_sample (i_right_sample),
        .i_ctrl   (ctrl_r),
        .o_word   (word_r)
    );

    sfmt_merge u_merge (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_in_valid),
        .o_stall      (o_in_stall),
        .i_left_word  (word_l),
        .i_right_word (word_r),
        .o_valid      (o_out_valid),
        .i_stall      (i_out_stall),
        .o_word       (o_subframe_word),
        .o_last       (o_frame_done)
    );

endmodule
